FILE: sv/saic_pkg.sv
// Package for the set-associative instruction cache: geometry constants,
// payload structs, state and result-kind enums. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package saic_pkg;
    localparam int SETS           = 64;
    localparam int LINE_HALFWORDS = 8;
    localparam int WAYS           = 2;

    localparam int OFF_W  = $clog2(LINE_HALFWORDS);
    localparam int SET_W  = $clog2(SETS);
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int TAG_W  = 31 - OFF_W - SET_W;
    localparam int LINE_W = SET_W + OFF_W;

    localparam logic [7:0] MISS_PENALTY_RST = 8'd15;
    localparam logic [7:0] HIT_COST_RST     = 8'd1;

    typedef enum logic [1:0] {
        K_HIT  = 2'd0,
        K_MISS = 2'd1,
        K_FILL = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_FRD,
        S_FOUT
    } t_state;

    typedef enum logic {
        CFG_MISS_PENALTY = 1'b0,
        CFG_HIT_COST     = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        ACT_FETCH = 1'b0,
        ACT_FILL  = 1'b1
    } t_action;

    typedef struct packed {
        logic        action;
        logic [31:0] address;
        logic        new_fetch;
        logic [15:0] fill_data;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] data;
        logic [31:0] line_address;
        logic [2:0]  way;
        logic [31:0] hit_count;
        logic [31:0] miss_count;
        logic [31:0] cycle_count;
    } t_out;

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] hit_way;
        logic [WAY_W-1:0] victim;
    } t_look;
endpackage
`default_nettype wire

FILE: sv/saic_lookup.sv
// Tag compare and victim choice for one set of the instruction cache.
// Depends on saic_pkg.
`timescale 1ns / 1ps
`default_nettype none
module saic_lookup
    import saic_pkg::*;
(
    input  wire logic [WAYS-1:0][TAG_W-1:0] i_tags,
    input  wire logic [WAYS-1:0]            i_valid,
    input  wire logic [TAG_W-1:0]           i_tag,
    input  wire logic [31:0]                i_cycle,
    output t_look                           o_look
);
    logic             w_hit;
    logic [WAY_W-1:0] w_hit_way;
    logic             w_inv;
    logic [WAY_W-1:0] w_inv_way;

    // Walk downward so the lowest matching or invalid way wins.
    always_comb begin
        w_hit     = 1'b0;
        w_hit_way = '0;
        w_inv     = 1'b0;
        w_inv_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (i_valid[w] && (i_tags[w] == i_tag)) begin
                w_hit     = 1'b1;
                w_hit_way = WAY_W'(w);
            end
            if (!i_valid[w]) begin
                w_inv     = 1'b1;
                w_inv_way = WAY_W'(w);
            end
        end
        o_look.hit     = w_hit;
        o_look.hit_way = w_hit_way;
        o_look.victim  = w_inv ? w_inv_way : WAY_W'(i_cycle % WAYS);
    end
endmodule
`default_nettype wire

FILE: sv/set_assoc_icache_fill_replace_top.sv
// Top level of the set-associative instruction cache with line fill and a
// victim choice from the cycle counter. Depends on saic_pkg and saic_lookup.
`timescale 1ns / 1ps
`default_nettype none
//
//  Channel   Signals                               Handshake
//  -------   -----------------------------------   ------------------------------
//  command   i_start, o_busy, i_in (t_in)          beat when i_start && !o_busy
//  result    o_strobe, o_result (t_out)            beat on every o_strobe cycle
//  config    i_cfg_we, i_cfg_index, i_cfg_data     write when i_cfg_we is high
//
//  A fetch reads the tag and line memories synchronously, then compares in
//  S_LOOK and registers the result; a fetch taken while a fill is pending
//  gives no result. The last fill beat of a line goes on through S_FRD and
//  S_FOUT, since the requested halfword is read back from the line memory
//  after it is written. Reset is synchronous and active low; it clears the
//  valid bits, counters and control state; tag and line memories stay unreset.
//  The receiver cannot stall: each result is shown for exactly one cycle.
module set_assoc_icache_fill_replace_top
    import saic_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    output logic            o_busy,
    input  wire t_in        i_in,
    output logic            o_strobe,
    output t_out            o_result,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);
    // Tag memory holds all ways of a set in one row; the line memory holds
    // the same halfword of every way in one row, so one read serves a set.
    logic [WAYS-1:0][TAG_W-1:0] r_tag_mem  [SETS];
    logic [WAYS-1:0][15:0]      r_line_mem [SETS*LINE_HALFWORDS];
    logic [WAYS-1:0][TAG_W-1:0] r_tag_rd;
    logic [WAYS-1:0][15:0]      r_line_rd;
    logic [SETS-1:0][WAYS-1:0]  r_valid;

    t_state r_state, n_state;
    logic [7:0]  r_miss_pen, r_hit_cost;
    logic [31:0] r_hits, n_hits, r_misses, n_misses, r_cycles, n_cycles;
    logic [SET_W-1:0] r_last_set, n_last_set;
    logic        r_last_known, n_last_known;
    logic        r_fill_busy, n_fill_busy;
    logic [WAY_W-1:0] r_fill_way, n_fill_way;
    logic [SET_W-1:0] r_fill_set, n_fill_set;
    logic [OFF_W-1:0] r_fill_pos, n_fill_pos;
    logic [OFF_W-1:0] r_pend_off, n_pend_off;

    // Captured fetch request.
    logic [SET_W-1:0] r_set;
    logic [OFF_W-1:0] r_off;
    logic [TAG_W-1:0] r_tag;
    logic             r_new_fetch;

    logic  r_strobe, n_strobe;
    t_out  r_out, n_out;

    logic              w_accept;
    logic [SET_W-1:0]  w_in_set;
    logic [OFF_W-1:0]  w_in_off;
    logic [LINE_W-1:0] w_line_raddr;
    logic              w_line_we;
    logic              w_tag_we;
    t_look             w_look;
    logic              w_known;

    assign w_accept = i_start && (r_state == S_IDLE);
    assign w_in_off = i_in.address[OFF_W:1];
    assign w_in_set = i_in.address[OFF_W+SET_W:OFF_W+1];
    assign w_line_raddr = (r_state == S_FRD) ? {r_fill_set, r_pend_off}
                                             : {w_in_set, w_in_off};
    assign w_line_we = w_accept && (i_in.action == ACT_FILL) && r_fill_busy;
    assign w_known   = r_last_known && !r_new_fetch;

    saic_lookup u_lookup (
        .i_tags  (r_tag_rd),
        .i_valid (r_valid[r_set]),
        .i_tag   (r_tag),
        .i_cycle (r_cycles),
        .o_look  (w_look)
    );

    always_ff @(posedge i_clk) begin
        r_tag_rd  <= r_tag_mem[w_in_set];
        r_line_rd <= r_line_mem[w_line_raddr];
        if (w_tag_we) begin
            r_tag_mem[r_set][w_look.victim] <= r_tag;
        end
        if (w_line_we) begin
            r_line_mem[{r_fill_set, r_fill_pos}][r_fill_way] <= i_in.fill_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_set       <= w_in_set;
            r_off       <= w_in_off;
            r_tag       <= i_in.address[31:OFF_W+SET_W+1];
            r_new_fetch <= i_in.new_fetch;
        end
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_miss_pen   <= MISS_PENALTY_RST;
            r_hit_cost   <= HIT_COST_RST;
            r_hits       <= '0;
            r_misses     <= '0;
            r_cycles     <= '0;
            r_last_set   <= '0;
            r_last_known <= 1'b1;
            r_fill_busy  <= 1'b0;
            r_fill_way   <= '0;
            r_fill_set   <= '0;
            r_fill_pos   <= '0;
            r_pend_off   <= '0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_hits       <= n_hits;
            r_misses     <= n_misses;
            r_cycles     <= n_cycles;
            r_last_set   <= n_last_set;
            r_last_known <= n_last_known;
            r_fill_busy  <= n_fill_busy;
            r_fill_way   <= n_fill_way;
            r_fill_set   <= n_fill_set;
            r_fill_pos   <= n_fill_pos;
            r_pend_off   <= n_pend_off;
            r_strobe     <= n_strobe;
            if (w_tag_we) begin
                r_valid[r_set][w_look.victim] <= 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MISS_PENALTY: r_miss_pen <= i_cfg_data;
                    CFG_HIT_COST:     r_hit_cost <= i_cfg_data;
                    default:          r_miss_pen <= r_miss_pen;
                endcase
            end
        end
    end

    // Next state, counters and the result beat.
    always_comb begin
        n_state      = r_state;
        n_hits       = r_hits;
        n_misses     = r_misses;
        n_cycles     = r_cycles;
        n_last_set   = r_last_set;
        n_last_known = r_last_known;
        n_fill_busy  = r_fill_busy;
        n_fill_way   = r_fill_way;
        n_fill_set   = r_fill_set;
        n_fill_pos   = r_fill_pos;
        n_pend_off   = r_pend_off;
        n_strobe     = 1'b0;
        n_out        = r_out;
        w_tag_we     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in.action == ACT_FILL) begin
                        if (r_fill_busy) begin
                            n_fill_pos = r_fill_pos + 1'b1;
                            if (r_fill_pos == OFF_W'(LINE_HALFWORDS - 1)) begin
                                n_state = S_FRD;
                            end
                        end
                    end else if (!r_fill_busy) begin
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                n_state      = S_IDLE;
                n_strobe     = 1'b1;
                n_last_set   = r_set;
                n_last_known = 1'b1;
                n_out.line_address = '0;
                n_out.data         = '0;
                if (w_look.hit) begin
                    if (!(w_known && (r_last_set == r_set))) begin
                        n_hits   = r_hits + 32'd1;
                        n_cycles = r_cycles + {24'd0, r_hit_cost};
                    end
                    n_out.kind = K_HIT;
                    n_out.data = r_line_rd[w_look.hit_way];
                    n_out.way  = 3'(w_look.hit_way);
                end else begin
                    w_tag_we    = 1'b1;
                    n_misses    = r_misses + 32'd1;
                    n_cycles    = r_cycles + {24'd0, r_miss_pen};
                    n_fill_busy = 1'b1;
                    n_fill_way  = w_look.victim;
                    n_fill_set  = r_set;
                    n_fill_pos  = '0;
                    n_pend_off  = r_off;
                    n_out.kind  = K_MISS;
                    n_out.way   = 3'(w_look.victim);
                    n_out.line_address = {r_tag, r_set, {(OFF_W+1){1'b0}}};
                end
                n_out.hit_count   = n_hits;
                n_out.miss_count  = n_misses;
                n_out.cycle_count = n_cycles;
            end
            S_FRD: begin
                n_state = S_FOUT;
            end
            S_FOUT: begin
                n_state      = S_IDLE;
                n_strobe     = 1'b1;
                n_fill_busy  = 1'b0;
                n_fill_pos   = '0;
                n_out.kind         = K_FILL;
                n_out.data         = r_line_rd[r_fill_way];
                n_out.line_address = '0;
                n_out.way          = 3'(r_fill_way);
                n_out.hit_count    = r_hits;
                n_out.miss_count   = r_misses;
                n_out.cycle_count  = r_cycles;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

`ifndef NO_ASSERTIONS
    a_no_double_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("two result beats in a row");

    a_fill_beat_ends_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.kind == K_FILL)) |-> !r_fill_busy)
        else $error("fill result left the fill pending");

    a_miss_opens_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.kind == K_MISS)) |-> r_fill_busy)
        else $error("miss result without a pending fill");
`endif
endmodule
`default_nettype wire
